@@ sv/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-1 hasher package
// Shared constants, types and round helpers.
// ----------------------------------------------------------------------------
package sha1_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// one classified item handed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
	} sha1_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} sha1_digest_t;

	function automatic logic [31:0] sha1_f(input logic [6:0] rnd, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (rnd < 7'd20) f = (b & c) | (~b & d);
		else if (rnd < 7'd40) f = b ^ c ^ d;
		else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
		else f = b ^ c ^ d;
		return f;
	endfunction

	function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
		logic [31:0] k;
		if (rnd < 7'd20) k = K0;
		else if (rnd < 7'd40) k = K1;
		else if (rnd < 7'd60) k = K2;
		else k = K3;
		return k;
	endfunction

endpackage

@@ sv/sha1_stream_if.sv @@
// ----------------------------------------------------------------------------
// SHA-1 stream interface
// Valid/ready channel carrying a typed payload.
// ----------------------------------------------------------------------------
interface sha1_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ sv/sha1_byte_stream_hasher_unit.sv @@
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Byte-serial SHA-1 with padding and five-word digest output.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  in_ch     in   data_byte, byte_present, end_of_message
//  out_ch    out  digest_word, word_index, last_word
//
//  Bytes are taken while the core is idle; the 64th byte of a block starts a
//  compression (load, 80 rounds, add) in the one-round-per-cycle core.
//  An end item adds up to two pad sweeps and compressions.
//  Empty items are taken and dropped. A small queue decouples input from core.
//  Reset is asynchronous; hash state returns to the initial values.
module sha1_byte_stream_hasher_unit #(
	parameter int QueueDepth = sha1_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	sha1_stream_if.sink   in_ch,
	sha1_stream_if.source out_ch
);
	import sha1_pkg::*;

	sha1_item_t   in_item, q_item;
	sha1_digest_t dg;
	logic         q_valid, q_ready;

	assign in_item.data = in_ch.payload.data;
	assign in_item.present = in_ch.payload.present;
	assign in_item.last = in_ch.payload.last;

	sha1_front #(.Depth(QueueDepth)) u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item,
		.q_valid, .q_ready, .q_item
	);

	sha1_core u_core (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_item,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_digest(dg)
	);

	assign out_ch.payload.word = dg.word;
	assign out_ch.payload.index = dg.index;
	assign out_ch.payload.last = dg.last;
endmodule

@@ sv/sha1_front.sv @@
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accepts items, drops empty ones, and queues the rest for the core.
// ----------------------------------------------------------------------------
module sha1_front #(
	parameter int Depth = sha1_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sha1_pkg::sha1_item_t in_item,
	output logic                 q_valid,
	input  logic                 q_ready,
	output sha1_pkg::sha1_item_t q_item
);
	import sha1_pkg::*;

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	sha1_item_t      mem_q [Depth];
	logic [AW-1:0]   wptr_q, rptr_q;
	logic [AW:0]     count_q;
	logic            push, pop;

	assign in_ready = (count_q != (AW+1)'(Depth));
	// empty items change nothing: take them, do not queue them
	assign push = in_valid && in_ready && (in_item.present || in_item.last);
	assign q_valid = (count_q != '0);
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
			if (pop) rptr_q <= (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

@@ sv/sha1_core.sv @@
// ----------------------------------------------------------------------------
// SHA-1 back end
// Block buffer, padding, 80-round compression and digest output.
// ----------------------------------------------------------------------------
module sha1_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_ready,
	input  sha1_pkg::sha1_item_t   q_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sha1_pkg::sha1_digest_t out_digest
);
	import sha1_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LOAD  = 6'b000010,
		ST_ROUND = 6'b000100,
		ST_ADD   = 6'b001000,
		ST_PAD   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t       state_q;
	logic [31:0]  buf_q [16];
	logic [31:0]  w_q [16];
	logic [31:0]  h_q [5];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [6:0]   fill_q;
	logic [63:0]  len_q;
	logic [6:0]   rnd_q;
	logic [4:0]   ld_q;
	logic         final_q;   // padding pending after current compression
	logic         lenblk_q;  // current block carries the length
	logic [2:0]   oidx_q;

	logic [31:0]  w_new, t_sum, w_cur;
	logic [3:0]   wi;

	assign wi = rnd_q[3:0];
	assign w_new = {w_q[(wi+4'd13)][30:0] ^ w_q[(wi+4'd8)][30:0] ^ w_q[(wi+4'd2)][30:0]
		^ w_q[wi][30:0],
		w_q[(wi+4'd13)][31] ^ w_q[(wi+4'd8)][31] ^ w_q[(wi+4'd2)][31] ^ w_q[wi][31]};
	assign w_cur = (rnd_q < 7'd16) ? w_q[wi] : w_new;
	assign t_sum = {a_q[26:0], a_q[31:27]} + sha1_f(rnd_q, b_q, c_q, d_q) + e_q
		+ w_cur + sha1_k(rnd_q);

	assign q_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_digest.word = h_q[oidx_q];
	assign out_digest.index = oidx_q;
	assign out_digest.last = (oidx_q == 3'd4);

	// byte write into the word buffer
	function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] pos,
			input logic [7:0] v);
		logic [31:0] r;
		r = w;
		case (pos)
			2'd0: r[31:24] = v;
			2'd1: r[23:16] = v;
			2'd2: r[15:8] = v;
			default: r[7:0] = v;
		endcase
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			if (q_item.present)
				buf_q[fill_q[5:2]] <= put_byte(buf_q[fill_q[5:2]], fill_q[1:0], q_item.data);
		end else if (state_q == ST_PAD) begin
			// one byte per cycle: 0x80, zeros, then length
			if (ld_q[0]) begin
				buf_q[fill_q[5:2]] <= put_byte(buf_q[fill_q[5:2]], fill_q[1:0], PAD_BYTE);
			end else if (fill_q < 7'd56 || !lenblk_q) begin
				buf_q[fill_q[5:2]] <= put_byte(buf_q[fill_q[5:2]], fill_q[1:0], 8'h00);
			end else begin
				buf_q[fill_q[5:2]] <= put_byte(buf_q[fill_q[5:2]], fill_q[1:0],
					len_q[8'(8'd63 - {fill_q[2:0], 3'b000}) -: 8]);
			end
		end
		if (state_q == ST_LOAD) begin
			for (int i = 0; i < 16; i++) w_q[i] <= buf_q[i];
		end else if (state_q == ST_ROUND && rnd_q >= 7'd16) begin
			w_q[wi] <= w_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			h_q[0] <= H0_INIT; h_q[1] <= H1_INIT; h_q[2] <= H2_INIT;
			h_q[3] <= H3_INIT; h_q[4] <= H4_INIT;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
			fill_q <= '0;
			len_q <= '0;
			rnd_q <= '0;
			ld_q <= '0;
			final_q <= 1'b0;
			lenblk_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_item.present) begin
							fill_q <= fill_q + 7'd1;
							len_q <= len_q + 64'd8;
						end
						final_q <= q_item.last;
						ld_q <= 5'd1;
						if (q_item.present && fill_q == 7'd63) state_q <= ST_LOAD;
						else if (q_item.last) state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					// ld_q[0] marks the 0x80 byte
					if (ld_q[0]) lenblk_q <= (fill_q < 7'd56);
					ld_q <= '0;
					fill_q <= fill_q + 7'd1;
					if (fill_q == 7'd63) begin
						final_q <= !(ld_q[0] ? (fill_q < 7'd56) : lenblk_q);
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					fill_q <= '0;
					rnd_q <= '0;
					a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2];
					d_q <= h_q[3]; e_q <= h_q[4];
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					a_q <= t_sum;
					b_q <= a_q;
					c_q <= {b_q[1:0], b_q[31:2]};
					d_q <= c_q;
					e_q <= d_q;
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) state_q <= ST_ADD;
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					oidx_q <= '0;
					if (lenblk_q) begin
						state_q <= ST_OUT;
					end else if (final_q) begin
						// second pad block carries only zeros and the length;
						// pad after a full block still starts with 0x80
						if (!ld_q[0]) lenblk_q <= 1'b1;
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd4) begin
							state_q <= ST_IDLE;
							h_q[0] <= H0_INIT; h_q[1] <= H1_INIT; h_q[2] <= H2_INIT;
							h_q[3] <= H3_INIT; h_q[4] <= H4_INIT;
							fill_q <= '0;
							len_q <= '0;
							lenblk_q <= 1'b0;
							final_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ sv/sha1_checker.sv @@
// ----------------------------------------------------------------------------
// SHA-1 port checker
// Port-level checks bound to the top level.
// ----------------------------------------------------------------------------
module sha1_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  word_index,
	input logic        last_word
);
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> word_index <= 3'd4) else $error("word index out of range");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd4))) else $error("last flag wrong");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_word) |=> out_valid
			&& word_index == $past(word_index) + 3'd1) else $error("digest order");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(word_index))
		else $error("transfer dropped");
endmodule

bind sha1_byte_stream_hasher_unit sha1_checker u_chk (
	.clk, .arst_n,
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.word_index(out_ch.payload.index), .last_word(out_ch.payload.last)
);

@@ dv/tb_sha1_byte_stream_hasher_unit.sv @@
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher testbench
// Drives random and directed messages with random idle cycles on both
// channels and compares every digest word against a behavioral SHA-1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sha1_byte_stream_hasher_unit;
	import sha1_pkg::*;

	localparam int IDLE_PCT  = 23;
	localparam int STALL_MAX = 200000;
	localparam int DRAIN_CYC = 400;

	logic clk;
	logic arst_n;

	sha1_stream_if #(.payload_t(sha1_item_t))   in_ch ();
	sha1_stream_if #(.payload_t(sha1_digest_t)) out_ch ();

	sha1_byte_stream_hasher_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// predictor state
	logic [31:0]  hw [5];
	logic [7:0]   blk [64];
	int           fill;
	logic [63:0]  nbits;

	sha1_item_t   pending [$];
	sha1_digest_t digest_q [$];
	int           errors;
	bit           no_idle;
	int           stall_cnt;
	logic         in_fire;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic hash_reset();
		hw[0] = H0_INIT; hw[1] = H1_INIT; hw[2] = H2_INIT;
		hw[3] = H3_INIT; hw[4] = H4_INIT;
		fill = 0;
		nbits = '0;
	endtask

	task automatic compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		a = hw[0]; b = hw[1]; c = hw[2]; d = hw[3]; e = hw[4];
		for (int i = 0; i < 80; i++) begin
			if (i >= 16)
				w[i%16] = rotl(w[(i+13)%16] ^ w[(i+8)%16] ^ w[(i+2)%16] ^ w[i%16], 1);
			if (i < 20) begin
				f = (b & c) | (~b & d); k = K0;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = K1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = K2;
			end else begin
				f = b ^ c ^ d; k = K3;
			end
			t = rotl(a, 5) + f + e + w[i%16] + k;
			e = d; d = c; c = rotl(b, 30); b = a; a = t;
		end
		hw[0] += a; hw[1] += b; hw[2] += c; hw[3] += d; hw[4] += e;
		fill = 0;
	endtask

	task automatic hash_item(input sha1_item_t it);
		sha1_digest_t dw;
		if (it.present) begin
			blk[fill] = it.data;
			fill++;
			nbits += 64'd8;
			if (fill == 64)
				compress();
		end
		if (!it.last)
			return;
		blk[fill] = PAD_BYTE;
		fill++;
		if (fill > 56) begin
			while (fill < 64) begin
				blk[fill] = 8'h00; fill++;
			end
			compress();
		end
		while (fill < 56) begin
			blk[fill] = 8'h00; fill++;
		end
		for (int i = 0; i < 8; i++)
			blk[56+i] = nbits[63-8*i -: 8];
		compress();
		for (int i = 0; i < 5; i++) begin
			dw.word  = hw[i];
			dw.index = 3'(i);
			dw.last  = (i == 4);
			digest_q.push_back(dw);
		end
		hash_reset();
	endtask

	task automatic add_msg(input int len, input bit trail_empty, input int gaps);
		sha1_item_t it;
		for (int i = 0; i < len; i++) begin
			it.data = 8'($urandom); it.present = 1'b1;
			it.last = (i == len - 1) && !trail_empty;
			pending.push_back(it);
			if (gaps > 0 && $urandom_range(0, 99) < gaps) begin
				it.data = 8'($urandom); it.present = 1'b0; it.last = 1'b0;
				pending.push_back(it);
			end
		end
		if (trail_empty || len == 0) begin
			it.data = 8'($urandom); it.present = 1'b0; it.last = 1'b1;
			pending.push_back(it);
		end
	endtask

	// driver; a held item is replaced only after its transfer
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid   <= 1'b0;
			in_ch.payload <= '0;
		end else if (!in_ch.valid || in_fire) begin
			if (pending.size() > 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
				in_ch.payload <= pending.pop_front();
				in_ch.valid   <= 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// handshake sampled at the rising edge
	always @(posedge clk) begin
		in_fire = arst_n && in_ch.valid && in_ch.ready;
		if (in_fire)
			hash_item(in_ch.payload);
	end

	// sink ready
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// monitor
	always @(posedge clk) begin
		sha1_digest_t exp_w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (digest_q.size() == 0) begin
				$error("unexpected digest word %h", out_ch.payload.word);
				errors++;
			end else begin
				exp_w = digest_q.pop_front();
				if (out_ch.payload.word !== exp_w.word) begin
					$error("digest_word exp %h got %h", exp_w.word, out_ch.payload.word);
					errors++;
				end
				if (out_ch.payload.index !== exp_w.index) begin
					$error("word_index exp %0d got %0d", exp_w.index, out_ch.payload.index);
					errors++;
				end
				if (out_ch.payload.last !== exp_w.last) begin
					$error("last_word exp %0d got %0d", exp_w.last, out_ch.payload.last);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			stall_cnt <= 0;
		else if (pending.size() > 0 || digest_q.size() > 0 || in_ch.valid) begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_MAX) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		sha1_item_t it;
		int n_items;
		errors = 0;
		no_idle = 0;
		hash_reset();
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty message, lone 0x00 byte after an empty item, FF AA 55 with empty end
		add_msg(0, 1'b1, 0);
		it = '{data: 8'hFF, present: 1'b0, last: 1'b0};
		pending.push_back(it);
		it = '{data: 8'h00, present: 1'b1, last: 1'b1};
		pending.push_back(it);
		it = '{data: 8'hFF, present: 1'b1, last: 1'b0};
		pending.push_back(it);
		it = '{data: 8'hAA, present: 1'b1, last: 1'b0};
		pending.push_back(it);
		it = '{data: 8'h55, present: 1'b1, last: 1'b0};
		pending.push_back(it);
		it = '{data: 8'h00, present: 1'b0, last: 1'b1};
		pending.push_back(it);
		// padding boundaries: two-block pad and exact block fill
		add_msg(56, 1'b0, 0);
		add_msg(64, 1'b0, 0);

		// random messages, short
		n_items = 0;
		while (n_items < 25) begin
			int len;
			len = $urandom_range(0, 12);
			n_items += len + 1;
			add_msg(len, $urandom_range(0, 3) == 0, 15);
		end

		// the long no-idle stretch sits in the middle of the run
		wait (pending.size() < 110);
		no_idle = 1;
		wait (pending.size() < 50);
		no_idle = 0;
		wait (pending.size() == 0);
		@(posedge clk);
		while (in_ch.valid) @(posedge clk);
		while (digest_q.size() > 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
